@@ hw/rtl/cdbs_pkg.sv @@
// ----------------------------------------------------------------------------
// cdbs_pkg
// Shared types and constants of the CSV delimiter block scanner: block
// geometry, register map, word types for both channels and lane results.
// ----------------------------------------------------------------------------
package cdbs_pkg;

    // block geometry and running offset width
    localparam int BLOCK_BYTES = 64;
    localparam int OFFSET_BITS = 32;
    localparam int LANE_BYTES  = 8;
    localparam int LANES       = (BLOCK_BYTES + LANE_BYTES - 1) / LANE_BYTES;
    localparam int IDX_BITS    = $clog2(BLOCK_BYTES);

    // fixed field widths
    localparam int LIMIT_BITS = 21;
    localparam int POS_BITS   = 32;
    localparam int ADDR_BITS  = 4;
    localparam int DATA_BITS  = 32;

    // special bytes
    localparam logic [7:0] QUOTE_BYTE   = 8'h22;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // register reset values
    localparam logic [7:0]            SEP_RESET   = 8'd44;
    localparam logic                  QUOTE_RESET = 1'b1;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 21'd65536;

    // register indexes, byte address is 4 times the index
    typedef enum logic [1:0] {
        REG_SEP_CHAR     = 2'd0,
        REG_QUOTE_ENABLE = 2'd1,
        REG_RECORD_LIMIT = 2'd2
    } t_reg_idx;

    typedef logic [BLOCK_BYTES-1:0] t_mask;
    typedef logic [OFFSET_BITS-1:0] t_offset;

    // configuration seen by the datapath
    typedef struct packed {
        logic [7:0]            sep_char;
        logic                  quote_enable;
        logic [LIMIT_BITS-1:0] record_limit;
    } t_cfg;

    // input word: one text block
    typedef struct packed {
        logic [63:0] bytes_0_7;
        logic [63:0] bytes_8_15;
        logic [63:0] bytes_16_23;
        logic [63:0] bytes_24_31;
        logic [63:0] bytes_32_39;
        logic [63:0] bytes_40_47;
        logic [63:0] bytes_48_55;
        logic [63:0] bytes_56_63;
        logic        new_batch;
    } t_in_word;

    // output word: one delimiter
    typedef struct packed {
        logic [POS_BITS-1:0] position;
        logic                last_of_block;
        logic                limit_reached;
    } t_out_word;

    // what one lane finds in its eight bytes
    typedef struct packed {
        logic [LANE_BYTES-1:0] delim;
        logic [LANE_BYTES-1:0] qpre;
    } t_lane_res;

endpackage

@@ hw/rtl/csv_delimiter_block_scanner_top.sv @@
// ----------------------------------------------------------------------------
// csv_delimiter_block_scanner_top
// Scans 64-byte CSV blocks in eight parallel lanes, masks quoted bytes and
// sends the offset plus one of every delimiter, up to a record limit.
//
//   channel  direction  handshake              word
//   in       input      i_in_valid/o_in_stall  t_in_word, one text block
//   out      output     o_out_valid/i_out_stall t_out_word, one delimiter
//   cfg      input      psel/penable/pready    32-bit registers at 0, 4, 8
//
// A block is taken when its delimiter mask is built, and o_in_stall then
// stays high while any of its delimiters is still to be emitted; the
// emitter sends one position per cycle while the output is not stalled.
// Reset clears offset, count, quote and limit state and the output valid.
// A stalled output holds its word and stops emission.
// ----------------------------------------------------------------------------
module csv_delimiter_block_scanner_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  cdbs_pkg::t_in_word             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output cdbs_pkg::t_out_word            o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cdbs_pkg::ADDR_BITS-1:0] paddr,
    input  logic [cdbs_pkg::DATA_BITS-1:0] pwdata,
    output logic [cdbs_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready
);

    cdbs_pkg::t_cfg                          w_cfg;
    logic [7:0][63:0]                        w_fields;
    cdbs_pkg::t_lane_res [cdbs_pkg::LANES-1:0] w_lanes;
    cdbs_pkg::t_mask                         w_mask;
    logic                                    w_busy;
    logic                                    w_load;

    // registers
    cdbs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // block fields in byte order
    assign w_fields[0] = i_in_data.bytes_0_7;
    assign w_fields[1] = i_in_data.bytes_8_15;
    assign w_fields[2] = i_in_data.bytes_16_23;
    assign w_fields[3] = i_in_data.bytes_24_31;
    assign w_fields[4] = i_in_data.bytes_32_39;
    assign w_fields[5] = i_in_data.bytes_40_47;
    assign w_fields[6] = i_in_data.bytes_48_55;
    assign w_fields[7] = i_in_data.bytes_56_63;

    // scan lanes, bytes past the block end are disabled
    for (genvar j = 0; j < cdbs_pkg::LANES; j++) begin : g_lane
        logic [cdbs_pkg::LANE_BYTES-1:0] w_en;

        always_comb begin
            for (int b = 0; b < cdbs_pkg::LANE_BYTES; b++) begin
                w_en[b] = (j * cdbs_pkg::LANE_BYTES + b) < cdbs_pkg::BLOCK_BYTES;
            end
        end

        cdbs_lane u_lane (
            .i_bytes   (w_fields[j]),
            .i_byte_en (w_en),
            .i_cfg     (w_cfg),
            .o_res     (w_lanes[j])
        );
    end

    // input handshake
    assign o_in_stall = w_busy;
    assign w_load     = i_in_valid && !w_busy;

    // lane merge and quote carry
    cdbs_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_new_batch (i_in_data.new_batch),
        .i_quote_en  (w_cfg.quote_enable),
        .i_lanes     (w_lanes),
        .o_mask      (w_mask)
    );

    // position emitter
    cdbs_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_load),
        .i_mask         (w_mask),
        .i_new_batch    (i_in_data.new_batch),
        .i_record_limit (w_cfg.record_limit),
        .i_out_stall    (i_out_stall),
        .o_busy         (w_busy),
        .o_out_valid    (o_out_valid),
        .o_out_data     (o_out_data)
    );

endmodule

@@ hw/rtl/cdbs_cfg.sv @@
// ----------------------------------------------------------------------------
// cdbs_cfg
// APB-style register file: separator byte, quote enable and record limit.
// ----------------------------------------------------------------------------
module cdbs_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [cdbs_pkg::ADDR_BITS-1:0] paddr,
    input  logic [cdbs_pkg::DATA_BITS-1:0] pwdata,
    output logic [cdbs_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    output cdbs_pkg::t_cfg                 o_cfg
);

    logic [7:0]                      r_sep_char;
    logic                            r_quote_enable;
    logic [cdbs_pkg::LIMIT_BITS-1:0] r_record_limit;
    cdbs_pkg::t_reg_idx              w_idx;
    logic                            w_wr;

    assign pready = 1'b1;
    assign w_idx  = cdbs_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep_char     <= cdbs_pkg::SEP_RESET;
            r_quote_enable <= cdbs_pkg::QUOTE_RESET;
            r_record_limit <= cdbs_pkg::LIMIT_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                cdbs_pkg::REG_SEP_CHAR:     r_sep_char     <= pwdata[7:0];
                cdbs_pkg::REG_QUOTE_ENABLE: r_quote_enable <= pwdata[0];
                cdbs_pkg::REG_RECORD_LIMIT:
                    r_record_limit <= pwdata[cdbs_pkg::LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (w_idx)
            cdbs_pkg::REG_SEP_CHAR:     prdata = cdbs_pkg::DATA_BITS'(r_sep_char);
            cdbs_pkg::REG_QUOTE_ENABLE: prdata = cdbs_pkg::DATA_BITS'(r_quote_enable);
            cdbs_pkg::REG_RECORD_LIMIT: prdata = cdbs_pkg::DATA_BITS'(r_record_limit);
            default:                    prdata = '0;
        endcase
    end

    assign o_cfg.sep_char     = r_sep_char;
    assign o_cfg.quote_enable = r_quote_enable;
    assign o_cfg.record_limit = r_record_limit;

endmodule

@@ hw/rtl/cdbs_lane.sv @@
// ----------------------------------------------------------------------------
// cdbs_lane
// One scan lane: classifies eight text bytes and forms the local running
// XOR of quote bytes within the lane.
// ----------------------------------------------------------------------------
module cdbs_lane (
    input  logic [63:0]                     i_bytes,
    input  logic [cdbs_pkg::LANE_BYTES-1:0] i_byte_en,
    input  cdbs_pkg::t_cfg                  i_cfg,
    output cdbs_pkg::t_lane_res             o_res
);

    logic [cdbs_pkg::LANE_BYTES-1:0] w_quote;
    logic [cdbs_pkg::LANE_BYTES-1:0] w_delim;
    logic [cdbs_pkg::LANE_BYTES-1:0] w_qpre;

    // per byte compare
    always_comb begin
        for (int b = 0; b < cdbs_pkg::LANE_BYTES; b++) begin
            w_quote[b] = i_byte_en[b] && i_cfg.quote_enable &&
                         (i_bytes[8*b +: 8] == cdbs_pkg::QUOTE_BYTE);
            w_delim[b] = i_byte_en[b] &&
                         ((i_bytes[8*b +: 8] == i_cfg.sep_char) ||
                          (i_bytes[8*b +: 8] == cdbs_pkg::NEWLINE_BYTE));
        end
    end

    // inclusive running xor of quotes inside the lane
    always_comb begin
        w_qpre[0] = w_quote[0];
        for (int b = 1; b < cdbs_pkg::LANE_BYTES; b++) begin
            w_qpre[b] = w_qpre[b-1] ^ w_quote[b];
        end
    end

    assign o_res.delim = w_delim;
    assign o_res.qpre  = w_qpre;

endmodule

@@ hw/rtl/cdbs_merge.sv @@
// ----------------------------------------------------------------------------
// cdbs_merge
// Merging stage: chains the lane quote parities with the carried quote
// state, masks quoted delimiters and keeps the quote state across blocks.
// ----------------------------------------------------------------------------
module cdbs_merge (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_load,
    input  logic                                   i_new_batch,
    input  logic                                   i_quote_en,
    input  cdbs_pkg::t_lane_res [cdbs_pkg::LANES-1:0] i_lanes,
    output cdbs_pkg::t_mask                        o_mask
);

    logic                       r_quote;
    logic                       n_quote;
    logic [cdbs_pkg::LANES:0]   w_carry;

    // quote carry into each lane
    always_comb begin
        w_carry[0] = i_new_batch ? 1'b0 : r_quote;
        for (int j = 0; j < cdbs_pkg::LANES; j++) begin
            w_carry[j+1] = w_carry[j] ^ i_lanes[j].qpre[cdbs_pkg::LANE_BYTES-1];
        end
    end

    // delimiters that lie outside quotes
    always_comb begin
        for (int k = 0; k < cdbs_pkg::BLOCK_BYTES; k++) begin
            o_mask[k] = i_lanes[k / cdbs_pkg::LANE_BYTES].delim[k % cdbs_pkg::LANE_BYTES] &&
                        !(i_quote_en &&
                          (w_carry[k / cdbs_pkg::LANE_BYTES] ^
                           i_lanes[k / cdbs_pkg::LANE_BYTES].qpre[k % cdbs_pkg::LANE_BYTES]));
        end
    end

    // quote state is held while quotes are ignored, but a new batch still clears it
    assign n_quote = i_quote_en ? w_carry[cdbs_pkg::LANES] : w_carry[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote <= 1'b0;
        end else if (i_load) begin
            r_quote <= n_quote;
        end
    end

endmodule

@@ hw/rtl/cdbs_emit.sv @@
// ----------------------------------------------------------------------------
// cdbs_emit
// Emitter: holds the delimiter mask of one block, sends one position per
// word lowest byte first, counts delimiters and stops at the record limit.
// ----------------------------------------------------------------------------
module cdbs_emit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  cdbs_pkg::t_mask                 i_mask,
    input  logic                            i_new_batch,
    input  logic [cdbs_pkg::LIMIT_BITS-1:0] i_record_limit,
    input  logic                            i_out_stall,
    output logic                            o_busy,
    output logic                            o_out_valid,
    output cdbs_pkg::t_out_word             o_out_data
);

    cdbs_pkg::t_offset               r_offset;
    cdbs_pkg::t_offset               r_base;
    cdbs_pkg::t_mask                 r_mask;
    logic [cdbs_pkg::LIMIT_BITS-1:0] r_count;
    logic                            r_limit_hit;
    logic                            r_out_valid;
    cdbs_pkg::t_out_word             r_out_data;

    cdbs_pkg::t_offset               w_base;
    cdbs_pkg::t_mask                 w_low;
    cdbs_pkg::t_mask                 w_rest;
    logic [cdbs_pkg::IDX_BITS-1:0]   w_idx;
    logic [cdbs_pkg::LIMIT_BITS-1:0] n_count;
    cdbs_pkg::t_offset               w_pos;
    logic                            w_hit;
    logic                            w_emit;
    logic                            w_lim_eff;

    // start of a new batch clears offset, count and limit flag
    assign w_base    = i_new_batch ? '0 : r_offset;
    assign w_lim_eff = i_new_batch ? 1'b0 : r_limit_hit;

    // lowest pending delimiter
    assign w_low  = r_mask & (~r_mask + cdbs_pkg::BLOCK_BYTES'(1));
    assign w_rest = r_mask & ~w_low;

    always_comb begin
        w_idx = '0;
        for (int k = 0; k < cdbs_pkg::BLOCK_BYTES; k++) begin
            if (w_low[k]) begin
                w_idx = w_idx | cdbs_pkg::IDX_BITS'(k);
            end
        end
    end

    // position, count and limit test
    assign w_pos   = r_base + cdbs_pkg::OFFSET_BITS'(w_idx) + cdbs_pkg::OFFSET_BITS'(1);
    assign n_count = r_count + cdbs_pkg::LIMIT_BITS'(1);
    assign w_hit   = (n_count >= i_record_limit);
    assign w_emit  = (r_mask != '0) && (!r_out_valid || !i_out_stall);

    // block state and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_mask      <= '0;
            r_count     <= '0;
            r_limit_hit <= 1'b0;
        end else if (i_load) begin
            r_offset    <= w_base + cdbs_pkg::OFFSET_BITS'(cdbs_pkg::BLOCK_BYTES);
            r_mask      <= w_lim_eff ? '0 : i_mask;
            r_count     <= i_new_batch ? '0 : r_count;
            r_limit_hit <= w_lim_eff;
        end else if (w_emit) begin
            r_mask      <= w_hit ? '0 : w_rest;
            r_count     <= n_count;
            r_limit_hit <= w_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_base <= w_base;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data.position      <= cdbs_pkg::POS_BITS'(w_pos);
            r_out_data.last_of_block <= (w_rest == '0) || w_hit;
            r_out_data.limit_reached <= w_hit;
        end
    end

    assign o_busy      = (r_mask != '0);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // a reached limit leaves nothing pending
    a_limit_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_limit_hit |-> (r_mask == '0))
        else $error("delimiters pending after limit reached");

    // a block is loaded only when the previous one is done
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> !o_busy)
        else $error("block loaded while emitter busy");

    // the word that reaches the limit closes the block
    a_limit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.limit_reached) |-> o_out_data.last_of_block)
        else $error("limit word not marked last of block");

    // an emitted word follows from pending work
    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> ($past(r_mask) != '0))
        else $error("word emitted without pending delimiter");

endmodule

@@ tb/cdbs_delim_checker.sv @@
// ----------------------------------------------------------------------------
// cdbs_delim_checker
// Watches the block, delimiter and register channels of the CSV delimiter
// block scanner. Every accepted text block is scanned here with an own copy
// of the quote, offset, count and limit state. The resulting positions are
// queued, and each delimiter word the block sends is compared field by
// field with the oldest queued one.
// ----------------------------------------------------------------------------
module cdbs_delim_checker
    import cdbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in_word             i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out_word            i_out_data,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [ADDR_BITS-1:0] i_paddr,
    input  logic [DATA_BITS-1:0] i_pwdata,
    input  logic                 i_pready,
    output int                   o_fail_count,
    output int                   o_pending
);

    // shadow registers
    logic [7:0]            sep_q;
    logic                  quote_en_q;
    logic [LIMIT_BITS-1:0] limit_q;

    // scanner state as the block should hold it
    t_offset               offset_q;
    logic                  in_quote_q;
    logic [LIMIT_BITS-1:0] count_q;
    logic                  limit_hit_q;

    t_out_word             position_q [$];
    t_out_word             want;
    int                    mismatches;

    // scan one block and queue the delimiter words it should produce
    function automatic void predict_delimiters(input t_in_word w);
        logic [63:0] lane [LANES];
        logic [7:0]  c;
        logic        q;
        logic        is_delim;
        t_out_word   res;
        t_out_word   found [$];
        int          k;
        lane[0] = w.bytes_0_7;
        lane[1] = w.bytes_8_15;
        lane[2] = w.bytes_16_23;
        lane[3] = w.bytes_24_31;
        lane[4] = w.bytes_32_39;
        lane[5] = w.bytes_40_47;
        lane[6] = w.bytes_48_55;
        lane[7] = w.bytes_56_63;
        if (w.new_batch) begin
            offset_q    = '0;
            in_quote_q  = 1'b0;
            count_q     = '0;
            limit_hit_q = 1'b0;
        end
        q = in_quote_q;
        for (k = 0; k < BLOCK_BYTES; k++) begin
            c = lane[k/8][8*(k%8) +: 8];
            // quote toggles before the byte itself is tested
            if (quote_en_q && c == QUOTE_BYTE) begin
                q = ~q;
            end
            is_delim = (c == sep_q || c == NEWLINE_BYTE) && !(quote_en_q && q);
            if (is_delim && !limit_hit_q) begin
                count_q           = count_q + 1'b1;
                res.position      = offset_q + t_offset'(k + 1);
                res.last_of_block = 1'b0;
                res.limit_reached = (count_q >= limit_q);
                if (res.limit_reached) begin
                    limit_hit_q = 1'b1;
                end
                found.push_back(res);
            end
        end
        // quote state is frozen while quotes are ignored
        if (quote_en_q) begin
            in_quote_q = q;
        end
        if (found.size() > 0) begin
            found[found.size()-1].last_of_block = 1'b1;
        end
        foreach (found[i]) begin
            position_q.push_back(found[i]);
        end
        offset_q = offset_q + t_offset'(BLOCK_BYTES);
    endfunction

    // register writes, block intake and delimiter compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sep_q       = SEP_RESET;
            quote_en_q  = QUOTE_RESET;
            limit_q     = LIMIT_RESET;
            offset_q    = '0;
            in_quote_q  = 1'b0;
            count_q     = '0;
            limit_hit_q = 1'b0;
            mismatches  = 0;
            position_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_SEP_CHAR:     sep_q = i_pwdata[7:0];
                    REG_QUOTE_ENABLE: quote_en_q = i_pwdata[0];
                    REG_RECORD_LIMIT: limit_q = i_pwdata[LIMIT_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_delimiters(i_in_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (position_q.size() == 0) begin
                    $display("%0t unexpected delimiter word: expected none, got %h",
                             $time, i_out_data);
                    mismatches++;
                end else begin
                    want = position_q.pop_front();
                    if (i_out_data.position !== want.position) begin
                        $display("%0t position: expected %0d, got %0d",
                                 $time, want.position, i_out_data.position);
                        mismatches++;
                    end
                    if (i_out_data.last_of_block !== want.last_of_block) begin
                        $display("%0t last_of_block at %0d: expected %b, got %b", $time,
                                 want.position, want.last_of_block,
                                 i_out_data.last_of_block);
                        mismatches++;
                    end
                    if (i_out_data.limit_reached !== want.limit_reached) begin
                        $display("%0t limit_reached at %0d: expected %b, got %b", $time,
                                 want.position, want.limit_reached,
                                 i_out_data.limit_reached);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= position_q.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the CSV delimiter block scanner: a directed set of text
// blocks (extreme bytes, quotes across blocks, doubled quotes, disabled
// quotes, separator equal to quote, record limits), then random CSV-like
// and raw blocks under several register settings and idle patterns,
// including two long output holds. Checking is done by cdbs_delim_checker.
// ----------------------------------------------------------------------------
module tb;
    import cdbs_pkg::*;

    localparam int WATCHDOG_CYCLES = 4000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_CYCLES     = 300;
    localparam int PHASE_ITEMS     = 18;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out_data;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [ADDR_BITS-1:0] paddr       = '0;
    logic [DATA_BITS-1:0] pwdata      = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    int                   fail_count;
    int                   pending;
    int                   in_idle_pct   = 0;
    int                   out_stall_pct = 0;
    // number of long holds asked for so far
    int                   hold_reqs     = 0;
    logic [7:0]           sep_now       = SEP_RESET;
    logic [7:0]           text_buf [BLOCK_BYTES];
    int                   quiet_cycles  = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    csv_delimiter_block_scanner_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    cdbs_delim_checker delim_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // watchdog on cycles without any accepted word or register access
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stall, or a long hold when asked for
    initial begin : receiver
        int n;
        int holds_done;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != holds_done) begin
                holds_done = hold_reqs;
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    i_out_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // register write: setup cycle, then access cycle
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [7:0] sep, input logic qen,
                             input logic [LIMIT_BITS-1:0] lim);
        write_reg(REG_SEP_CHAR, DATA_BITS'(sep));
        write_reg(REG_QUOTE_ENABLE, DATA_BITS'(qen));
        write_reg(REG_RECORD_LIMIT, DATA_BITS'(lim));
        sep_now = sep;
    endtask

    // offer one block, with random idle cycles ahead of it
    task automatic send_block(input t_in_word w);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // wait until every queued delimiter has come out, plus a margin
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in_word pack_text(input logic nb);
        logic [63:0] lane [LANES];
        t_in_word    w;
        int          k;
        for (k = 0; k < BLOCK_BYTES; k++) begin
            lane[k/8][8*(k%8) +: 8] = text_buf[k];
        end
        w.bytes_0_7   = lane[0];
        w.bytes_8_15  = lane[1];
        w.bytes_16_23 = lane[2];
        w.bytes_24_31 = lane[3];
        w.bytes_32_39 = lane[4];
        w.bytes_40_47 = lane[5];
        w.bytes_48_55 = lane[6];
        w.bytes_56_63 = lane[7];
        w.new_batch   = nb;
        return w;
    endfunction

    function automatic void fill_text(input logic [7:0] b);
        foreach (text_buf[k]) text_buf[k] = b;
    endfunction

    function automatic void put_text(input int at, input string s);
        int i;
        for (i = 0; i < s.len(); i++) text_buf[at+i] = s[i];
    endfunction

    task automatic send_text(input logic nb);
        send_block(pack_text(nb));
    endtask

    // mostly CSV-like text, sometimes raw bytes
    function automatic t_in_word random_block();
        int k;
        int r;
        int raw;
        raw = ($urandom_range(99) < 15);
        for (k = 0; k < BLOCK_BYTES; k++) begin
            r = $urandom_range(99);
            if (raw || (r >= 19 && r < 25)) text_buf[k] = 8'($urandom_range(255));
            else if (r < 9)  text_buf[k] = sep_now;
            else if (r < 13) text_buf[k] = NEWLINE_BYTE;
            else if (r < 19) text_buf[k] = QUOTE_BYTE;
            else             text_buf[k] = 8'("a") + 8'($urandom_range(25));
        end
        return pack_text($urandom_range(99) < 12);
    endfunction

    initial begin : stimulus
        int p;
        int i;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: comma, quotes on, large limit
        fill_text(8'h00); send_text(1'b1);
        fill_text(8'hFF); send_text(1'b0);
        fill_text(","); send_text(1'b0);
        fill_text(NEWLINE_BYTE); send_text(1'b0);
        fill_text(8'h00);
        put_text(0, "name,age,city\nbob,42,\"paris, fr\"\nann,7,oslo\n");
        send_text(1'b0);
        // doubled quotes inside a quoted field
        fill_text(" "); put_text(0, "\"say \"\"hi, there\"\"\",x\n"); send_text(1'b0);
        // quoted field running over a block boundary
        fill_text("a"); put_text(56, "b,c,\"d,e"); send_text(1'b0);
        fill_text("a"); put_text(0, "f,g\"\nh,i\n"); send_text(1'b0);
        fill_text("z"); put_text(0, ",\"q,r"); send_text(1'b0);
        // new batch drops the open quote; delimiters on first and last byte
        fill_text("x"); text_buf[0] = ","; text_buf[63] = NEWLINE_BYTE; send_text(1'b1);
        fill_text("k"); put_text(20, "m,\"open,"); send_text(1'b0);
        settle();

        // quotes ignored, open quote state is kept
        configure(",", 1'b0, LIMIT_RESET);
        fill_text(8'h00); put_text(0, "a,\"b,c\"\n\"\"d,e"); send_text(1'b0);
        settle();
        configure(",", 1'b1, LIMIT_RESET);
        fill_text("y"); put_text(0, "x,y\"z,w\n"); send_text(1'b0);
        settle();

        // separator is the quote byte
        configure(QUOTE_BYTE, 1'b1, LIMIT_RESET);
        fill_text("p"); put_text(0, "a\"b\"c,\"\n\"x"); send_text(1'b0);
        settle();
        configure(8'h00, 1'b1, LIMIT_RESET);
        fill_text(8'h00); send_text(1'b0);
        settle();
        configure(8'hFF, 1'b1, LIMIT_RESET);
        fill_text(8'hFF); send_text(1'b0);
        settle();

        // smallest limit, then dropped delimiters until a new batch
        configure(",", 1'b1, 21'd1);
        fill_text(","); send_text(1'b1);
        fill_text(","); send_text(1'b0);
        fill_text("a"); put_text(0, "a,b"); send_text(1'b1);
        settle();
        // limit of 1048576, then lowered below the count
        configure(",", 1'b1, 21'd1048576);
        fill_text(","); send_text(1'b1);
        settle();
        configure(",", 1'b1, 21'd10);
        fill_text("a"); put_text(0, "a,b\n"); send_text(1'b0);
        fill_text("b"); put_text(0, ",,,,,,,,,,,,,,,,"); send_text(1'b1);
        settle();

        // random phases
        for (p = 0; p < 5; p++) begin
            case (p)
                0: begin
                    configure(",", 1'b1, LIMIT_RESET);
                    in_idle_pct = 0;  out_stall_pct = 0;
                end
                1: begin
                    configure(";", 1'b1, 21'd1048576);
                    in_idle_pct = 83; out_stall_pct = 0;
                end
                2: begin
                    configure(8'($urandom_range(255)), 1'b0,
                              LIMIT_BITS'($urandom_range(60, 5)));
                    in_idle_pct = 0;  out_stall_pct = 83;
                end
                3: begin
                    configure(8'h09, 1'b1, 21'd30);
                    in_idle_pct = 14; out_stall_pct = 14;
                    hold_reqs++;
                end
                default: begin
                    configure(8'($urandom_range(255)), 1'($urandom_range(1)), 21'd3);
                    in_idle_pct = 0;  out_stall_pct = 0;
                    hold_reqs++;
                end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++) begin
                send_block(random_block());
            end
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
